/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared shorthand for clocked properties with reset disable
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RWS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RWS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/rws_pkg.sv */
// ----------------------------------------------------------------------------
// rws_pkg
// types and constants of the resampling wheel selector
// ----------------------------------------------------------------------------
`default_nettype none

package rws_pkg;

  localparam int CNT_W     = 11;
  localparam int WEIGHT_W  = 32;
  localparam int RAND_IN_W = 16;
  localparam int BETA_W    = 34;
  localparam int STEP_W    = CNT_W + 2;
  localparam int CMD_W     = 2;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 3;

  localparam logic [CNT_W-1:0]  COUNT_RESET = 11'd1024;
  localparam logic [CNT_W-1:0]  COUNT_MAX   = 11'd2047;
  localparam logic [BETA_W-1:0] BETA_MAX    = {BETA_W{1'b1}};

  // register index, taken from paddr[ADDR_W-1]
  localparam logic REG_PARTICLE_COUNT = 1'b0;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_DRAW  = 2'd2
  } cmd_t;

endpackage

`default_nettype wire

/* sv/rws_weight_mem.sv */
// ----------------------------------------------------------------------------
// rws_weight_mem
// particle weight store, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module rws_weight_mem
  import rws_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic                clk,
  input  wire logic                wr_en,
  input  wire logic [AW-1:0]       wr_addr,
  input  wire logic [WEIGHT_W-1:0] wr_data,
  input  wire logic [AW-1:0]       rd_addr,
  output logic      [WEIGHT_W-1:0] rd_data_r
);

  logic [WEIGHT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* sv/rws_mul.sv */
// ----------------------------------------------------------------------------
// rws_mul
// shared registered multiplier for wheel start and beta step
// ----------------------------------------------------------------------------
`default_nettype none

module rws_mul
  import rws_pkg::*;
#(
  parameter int A_W = 32,
  parameter int B_W = 16
) (
  input  wire logic               clk,
  input  wire logic [A_W-1:0]     a,
  input  wire logic [B_W-1:0]     b,
  output logic      [A_W+B_W-1:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
  end

endmodule

`default_nettype wire

/* sv/resampling_wheel_selector.sv */
// ----------------------------------------------------------------------------
// resampling_wheel_selector
// particle filter resampling wheel: weight load, wheel start, draws
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// in_       input      in_valid / in_stall    in_command, in_weight, in_random_fraction
// out_      output     out_valid / out_stall  out_selected_index, out_last_draw
// cfg       apb write  psel penable pwrite    paddr, pwdata, prdata (particle_count)
//
// load: writes the weight store and does not stall; start: multiply, then index setup
// draw: multiply, beta add, then a walk of at most 4*N weights, one store read each, then output
// the walk rate is set by the single weight store read port
// in_stall is high while a start or draw item is in flight
// a draw result waits in the output register until taken; reset is synchronous
// ----------------------------------------------------------------------------
`default_nettype none

module resampling_wheel_selector
  import rws_pkg::*;
#(
  parameter int MAX_PARTICLES = 1024,
  parameter int RANDOM_BITS   = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [CMD_W-1:0]                   in_command,
  input  wire logic [WEIGHT_W-1:0]                in_weight,
  input  wire logic [RAND_IN_W-1:0]               in_random_fraction,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [$clog2(MAX_PARTICLES)-1:0]        out_selected_index,
  output logic                                    out_last_draw,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [ADDR_W-1:0]                  paddr,
  input  wire logic [DATA_W-1:0]                  pwdata,
  output logic      [DATA_W-1:0]                  prdata,
  output logic                                    pready
);

  localparam int IDX_W  = $clog2(MAX_PARTICLES);
  localparam int RW     = (RANDOM_BITS < RAND_IN_W) ? RANDOM_BITS : RAND_IN_W;
  localparam int CMP_W  = (IDX_W > CNT_W) ? IDX_W : CNT_W;
  localparam int PROD_W = WEIGHT_W + RW;
  localparam int ADD_W  = PROD_W + 1;
  localparam int SUM_W  = ((ADD_W > BETA_W) ? ADD_W : BETA_W) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_WALK,
    S_OUT
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    pcount_r, pcount_nxt;
  logic [WEIGHT_W-1:0] max_r, max_nxt;
  logic [CNT_W-1:0]    lp_r, lp_nxt;
  logic [IDX_W-1:0]    widx_r, widx_nxt;
  logic [BETA_W-1:0]   beta_r, beta_nxt;
  logic [CNT_W-1:0]    dc_r, dc_nxt;
  logic [STEP_W-1:0]   steps_r, steps_nxt;
  logic                is_draw_r, is_draw_nxt;
  logic [RW-1:0]       rfrac_r, rfrac_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]    out_idx_r, out_idx_nxt;
  logic                out_last_r, out_last_nxt;

  logic [CNT_W-1:0]    n_act;
  logic [STEP_W-1:0]   limit;
  logic [WEIGHT_W-1:0] mul_a;
  logic [PROD_W-1:0]   prod;
  logic [PROD_W-1:0]   start_q;
  logic [ADD_W-1:0]    add_q;
  logic [SUM_W-1:0]    beta_sum;
  logic [BETA_W-1:0]   beta_sat;
  logic [IDX_W-1:0]    idx_start;
  logic [CMP_W:0]      inc_w;
  logic [IDX_W-1:0]    idx_inc;
  logic [CNT_W:0]      lp_inc;
  logic [WEIGHT_W-1:0] wt;
  logic                take_step;
  logic                mem_we;
  logic [IDX_W-1:0]    rd_addr;
  logic                cfg_wr;

  // active particle count
  always_comb begin
    if (pcount_r == '0) begin
      n_act = CNT_W'(1);
    end else if (32'(pcount_r) > 32'(MAX_PARTICLES)) begin
      n_act = CNT_W'(MAX_PARTICLES);
    end else begin
      n_act = pcount_r;
    end
  end

  assign limit = {n_act, 2'b00};
  assign mul_a = is_draw_r ? max_r : WEIGHT_W'(n_act);

  rws_mul #(
    .A_W (WEIGHT_W),
    .B_W (RW)
  ) u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (rfrac_r),
    .prod_r (prod)
  );

  assign start_q  = prod >> RANDOM_BITS;
  assign add_q    = {prod, 1'b0} >> RANDOM_BITS;
  assign beta_sum = SUM_W'(beta_r) + SUM_W'(add_q);
  assign beta_sat = (beta_sum > SUM_W'(BETA_MAX)) ? BETA_MAX : beta_sum[BETA_W-1:0];

  assign idx_start = (CMP_W'(widx_r) >= CMP_W'(n_act)) ? '0 : widx_r;
  assign inc_w     = (CMP_W+1)'(widx_r) + (CMP_W+1)'(1);
  assign idx_inc   = (inc_w >= (CMP_W+1)'(n_act)) ? '0 : inc_w[IDX_W-1:0];
  assign lp_inc    = (CNT_W+1)'(lp_r) + (CNT_W+1)'(1);

  assign take_step = (steps_r < limit) && (beta_r > BETA_W'(wt));
  assign rd_addr   = (state_r == S_ADD) ? idx_start : idx_inc;
  assign mem_we    = (state_r == S_IDLE) && in_valid && (in_command == CMD_LOAD);

  rws_weight_mem #(
    .DEPTH (MAX_PARTICLES),
    .AW    (IDX_W)
  ) u_mem (
    .clk       (clk),
    .wr_en     (mem_we),
    .wr_addr   (IDX_W'(lp_r)),
    .wr_data   (in_weight),
    .rd_addr   (rd_addr),
    .rd_data_r (wt)
  );

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[ADDR_W-1])
      REG_PARTICLE_COUNT: prdata = DATA_W'(pcount_r);
      default:            prdata = '0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    pcount_nxt    = pcount_r;
    max_nxt       = max_r;
    lp_nxt        = lp_r;
    widx_nxt      = widx_r;
    beta_nxt      = beta_r;
    dc_nxt        = dc_r;
    steps_nxt     = steps_r;
    is_draw_nxt   = is_draw_r;
    rfrac_nxt     = rfrac_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_idx_nxt   = out_idx_r;
    out_last_nxt  = out_last_r;

    if (cfg_wr && (paddr[ADDR_W-1] == REG_PARTICLE_COUNT)) begin
      pcount_nxt = pwdata[CNT_W-1:0];
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          rfrac_nxt = in_random_fraction[RW-1:0];
          unique case (in_command)
            CMD_LOAD: begin
              if ((lp_r == '0) || (in_weight > max_r)) begin
                max_nxt = in_weight;
              end
              lp_nxt = (lp_inc >= (CNT_W+1)'(n_act)) ? '0 : lp_inc[CNT_W-1:0];
            end
            CMD_START: begin
              is_draw_nxt = 1'b0;
              state_nxt   = S_MUL;
            end
            CMD_DRAW: begin
              is_draw_nxt = 1'b1;
              state_nxt   = S_MUL;
            end
            default: begin
            end
          endcase
        end
      end
      S_MUL: begin
        state_nxt = S_ADD;
      end
      S_ADD: begin
        if (is_draw_r) begin
          beta_nxt  = beta_sat;
          widx_nxt  = idx_start;
          steps_nxt = '0;
          state_nxt = S_WALK;
        end else begin
          widx_nxt  = (start_q >= PROD_W'(n_act)) ? IDX_W'(n_act - CNT_W'(1))
                                                   : start_q[IDX_W-1:0];
          beta_nxt  = '0;
          dc_nxt    = '0;
          lp_nxt    = '0;
          state_nxt = S_IDLE;
        end
      end
      S_WALK: begin
        if (take_step) begin
          beta_nxt  = beta_r - BETA_W'(wt);
          widx_nxt  = idx_inc;
          steps_nxt = steps_r + STEP_W'(1);
        end else begin
          dc_nxt    = (dc_r == COUNT_MAX) ? dc_r : dc_r + CNT_W'(1);
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = widx_r;
          out_last_nxt  = (dc_r == n_act);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pcount_r    <= COUNT_RESET;
      max_r       <= '0;
      lp_r        <= '0;
      widx_r      <= '0;
      beta_r      <= '0;
      dc_r        <= '0;
      steps_r     <= '0;
      is_draw_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pcount_r    <= pcount_nxt;
      max_r       <= max_nxt;
      lp_r        <= lp_nxt;
      widx_r      <= widx_nxt;
      beta_r      <= beta_nxt;
      dc_r        <= dc_nxt;
      steps_r     <= steps_nxt;
      is_draw_r   <= is_draw_nxt;
      out_valid_r <= out_valid_nxt;
      rfrac_r     <= rfrac_nxt;
      out_idx_r   <= out_idx_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_selected_index = out_idx_r;
  assign out_last_draw      = out_last_r;

endmodule

`default_nettype wire

/* sv/rws_checker.sv */
// ----------------------------------------------------------------------------
// rws_checker
// port-level checks of the resampling wheel selector
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rws_checker
  import rws_pkg::*;
#(
  parameter int IDX_W = 10
) (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_stall,
  input wire logic [CMD_W-1:0] in_command,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic [IDX_W-1:0] out_selected_index,
  input wire logic             out_last_draw
);

  logic acc;

  assign acc = in_valid && !in_stall;

  // held result
  `RWS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_selected_index) && $stable(out_last_draw), "stalled result item changed")

  // draw keeps the block busy
  `RWS_ASSERT_NXT(a_draw_busy, clk, rst_n, acc && (in_command == CMD_DRAW), in_stall, "draw item did not stall input")

  // load does not stall the input
  `RWS_ASSERT_NXT(a_load_free, clk, rst_n, acc && (in_command == CMD_LOAD), !in_stall, "load item stalled input")

  // start gives no result
  `RWS_ASSERT_NXT(a_start_quiet, clk, rst_n, acc && (in_command == CMD_START) && !out_valid, !out_valid, "start item produced a result")

endmodule

bind resampling_wheel_selector rws_checker #(
  .IDX_W (IDX_W)
) u_rws_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .in_command         (in_command),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_selected_index (out_selected_index),
  .out_last_draw      (out_last_draw)
);

`default_nettype wire

/* tb/rws_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rws_scoreboard
// watches the item, result and register ports of the resampling wheel
// selector, predicts every draw from its own copy of the weight store and
// wheel state, and compares each result field by field in order
// ----------------------------------------------------------------------------

module rws_scoreboard
  import rws_pkg::*;
#(
  parameter int SLOTS = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [CMD_W-1:0]           in_command,
  input  logic [WEIGHT_W-1:0]        in_weight,
  input  logic [RAND_IN_W-1:0]       in_random_fraction,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [$clog2(SLOTS)-1:0]   out_selected_index,
  input  logic                       out_last_draw,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ADDR_W-1:0]          paddr,
  input  logic [DATA_W-1:0]          pwdata,
  input  logic                       pready,
  output int                         fail_count,
  output int                         pending
);

  localparam int IDX_W = $clog2(SLOTS);

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic             last;
  } draw_result_t;

  logic [WEIGHT_W-1:0] weights [SLOTS];
  logic [WEIGHT_W-1:0] peak;
  logic [CNT_W-1:0]    load_pos;
  logic [CNT_W-1:0]    draw_total;
  logic [CNT_W-1:0]    count_cfg;
  logic [IDX_W-1:0]    wheel;
  logic [BETA_W-1:0]   beta;
  draw_result_t        picks_due[$];

  function automatic int unsigned usable_count(input logic [CNT_W-1:0] v);
    if (v == '0) return 1;
    if (v > SLOTS) return SLOTS;
    return 32'(v);
  endfunction

  task automatic advance_wheel(input logic [CMD_W-1:0] cmd, input logic [WEIGHT_W-1:0] w,
                               input logic [RAND_IN_W-1:0] r);
    int unsigned n;
    int unsigned idx;
    int unsigned steps;
    logic [63:0] acc;
    n = usable_count(count_cfg);
    case (cmd)
      CMD_LOAD: begin
        weights[load_pos[IDX_W-1:0]] = w;
        if (load_pos == '0 || w > peak) peak = w;
        if (load_pos + 1 >= n) load_pos = '0;
        else load_pos = load_pos + 1'b1;
      end
      CMD_START: begin
        idx = (32'(r) * n) >> RAND_IN_W;
        if (idx >= n) idx = n - 1;
        wheel = idx[IDX_W-1:0];
        beta = '0;
        draw_total = '0;
        load_pos = '0;
      end
      CMD_DRAW: begin
        acc = 64'(beta) + ((64'(r) * 64'd2 * 64'(peak)) >> RAND_IN_W);
        if (acc > 64'(BETA_MAX)) acc = 64'(BETA_MAX);
        idx = 32'(wheel);
        if (idx >= n) idx = 0;
        steps = 0;
        // walk round the wheel, bounded in case the weights never stop it
        while (steps < 4 * n && acc > 64'(weights[idx])) begin
          acc = acc - 64'(weights[idx]);
          idx = (idx + 1 >= n) ? 0 : idx + 1;
          steps++;
        end
        beta = acc[BETA_W-1:0];
        wheel = idx[IDX_W-1:0];
        if (draw_total != COUNT_MAX) draw_total = draw_total + 1'b1;
        picks_due.push_back('{index: idx[IDX_W-1:0], last: (draw_total == n)});
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    draw_result_t due;
    if (!rst_n) begin
      peak = '0;
      load_pos = '0;
      draw_total = '0;
      count_cfg = COUNT_RESET;
      wheel = '0;
      beta = '0;
      picks_due.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[ADDR_W-1] == REG_PARTICLE_COUNT)
        count_cfg = pwdata[CNT_W-1:0];
      if (out_valid && !out_stall) begin
        if (picks_due.size() == 0) begin
          $error("selected_index expected none actual %0d", out_selected_index);
          fail_count++;
        end else begin
          due = picks_due.pop_front();
          if (out_selected_index !== due.index) begin
            $error("selected_index expected %0d actual %0d", due.index, out_selected_index);
            fail_count++;
          end
          if (out_last_draw !== due.last) begin
            $error("last_draw expected %0d actual %0d", due.last, out_last_draw);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) advance_wheel(in_command, in_weight, in_random_fraction);
    end
    pending = picks_due.size();
  end

endmodule

/* tb/tb_resampling_wheel_selector.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_resampling_wheel_selector
// drives weight loads, wheel starts and draws with random gaps on both
// channels, walks the particle count through its extremes between phases,
// and reports the verdict from the scoreboard's failure count
// ----------------------------------------------------------------------------

module tb_resampling_wheel_selector;
  import rws_pkg::*;

  localparam int SLOTS         = 1024;
  localparam int IDX_W         = $clog2(SLOTS);
  localparam int RANDOM_ITEMS  = 400;
  localparam int EQUAL_LOADS   = 16;
  localparam int LONG_HOLD     = 200;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 20;
  localparam longint TIMEOUT_NS = 64'd20_000_000;

  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [CMD_W-1:0]      in_command;
  logic [WEIGHT_W-1:0]   in_weight;
  logic [RAND_IN_W-1:0]  in_random_fraction;
  logic                  out_valid;
  logic                  out_stall;
  logic [IDX_W-1:0]      out_selected_index;
  logic                  out_last_draw;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ADDR_W-1:0]     paddr;
  logic [DATA_W-1:0]     pwdata;
  logic [DATA_W-1:0]     prdata;
  logic                  pready;
  int                    fail_count;
  int                    pending;

  bit                    hold_req;
  bit                    send_quiet;
  bit                    take_quiet;
  bit                    loaded [SLOTS];
  int unsigned           fill_ptr;
  int unsigned           count_now;
  int unsigned           items_sent;

  resampling_wheel_selector uut (.*);

  rws_scoreboard #(.SLOTS(SLOTS)) u_scoreboard (.*);

  always #5 clk = ~clk;

  initial begin
    #(TIMEOUT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

  // result side: random hold-off after each result, one long hold on request
  initial begin
    int gap;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      gap = 0;
      if (hold_req) begin
        gap = LONG_HOLD;
        hold_req = 1'b0;
      end else if (rst_n && out_valid && !out_stall) begin
        if ($urandom_range(0, 31) == 0) take_quiet = !take_quiet;
        gap = take_quiet ? 0 : $urandom_range(0, 8);
      end
      if (gap > 0) begin
        @(negedge clk) out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic int unsigned clamp_count(input logic [CNT_W-1:0] v);
    if (v == '0) return 1;
    if (v > SLOTS) return SLOTS;
    return 32'(v);
  endfunction

  function automatic bit set_loaded();
    for (int i = 0; i < count_now; i++) if (!loaded[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [RAND_IN_W-1:0] rand_frac();
    return RAND_IN_W'($urandom);
  endfunction

  function automatic logic [WEIGHT_W-1:0] pick_weight(input int style);
    case (style)
      0: return $urandom;
      1: return $urandom_range(0, 15);
      2: return ($urandom_range(0, 7) == 0) ? $urandom : '0;
      default: return '0;
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] pick_count();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return CNT_W'($urandom_range(0, 2047));
    if (roll < 15) return CNT_W'(1);
    if (roll < 25) return CNT_W'($urandom_range(33, 128));
    return CNT_W'($urandom_range(2, 32));
  endfunction

  // called and returns at a falling edge
  task automatic send(input logic [CMD_W-1:0] cmd, input logic [WEIGHT_W-1:0] w,
                      input logic [RAND_IN_W-1:0] r);
    int gap;
    if ($urandom_range(0, 31) == 0) send_quiet = !send_quiet;
    gap = send_quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_weight <= w;
    in_random_fraction <= r;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (cmd == CMD_LOAD) begin
      loaded[fill_ptr] = 1'b1;
      fill_ptr = (fill_ptr + 1 >= count_now) ? 0 : fill_ptr + 1;
    end else if (cmd == CMD_START) begin
      fill_ptr = 0;
    end
    if (cmd != CMD_NONE) items_sent++;
  endtask

  task automatic load(input logic [WEIGHT_W-1:0] w);
    send(CMD_LOAD, w, rand_frac());
  endtask

  task automatic draw(input logic [RAND_IN_W-1:0] r);
    send(CMD_DRAW, $urandom, r);
  endtask

  task automatic start(input logic [RAND_IN_W-1:0] r);
    send(CMD_START, $urandom, r);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    while (in_stall) @(negedge clk);
  endtask

  task automatic set_count(input logic [CNT_W-1:0] value);
    settle();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {REG_PARTICLE_COUNT, 2'b00};
    pwdata <= DATA_W'(value);
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    count_now = clamp_count(value);
  endtask

  initial begin
    int unsigned base;
    int unsigned ndraw;
    int style;
    int roll;
    bit hold_done;
    bit holding;
    logic [CMD_W-1:0] cmd;
    logic [WEIGHT_W-1:0] w_eq;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_LOAD;
    in_weight = '0;
    in_random_fraction = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    count_now = clamp_count(COUNT_RESET);
    fill_ptr = 0;
    items_sent = 0;
    hold_done = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // equal weights at the reset count, each draw walks at most two steps
    w_eq = $urandom;
    start(16'h0000);
    repeat (EQUAL_LOADS) load(w_eq);
    draw(16'hFFFF);
    draw(16'h0000);
    repeat (3) draw(rand_frac());

    // count above the store size
    set_count(11'd2047);
    start(16'h0000);
    repeat (3) draw(rand_frac());

    // count of zero acts as one
    set_count(11'd0);
    start(16'hFFFF);
    load(32'd7);
    draw(16'hFFFF);
    draw(16'hFFFF);

    // extreme weights, ignored command, extra draw past the set
    set_count(11'd4);
    start(16'h0000);
    load(32'hFFFF_FFFF);
    load(32'h0);
    load(32'h1);
    load(32'h8000_0000);
    send(CMD_NONE, $urandom, rand_frac());
    start(16'hFFFF);
    draw(16'h0000);
    draw(16'hFFFF);
    draw(16'h8000);
    draw(16'h0001);
    draw(16'hFFFF);

    // walk on a zero weight, cut only by the step bound, until beta saturates
    set_count(11'd2);
    start(16'h0000);
    load(32'h0);
    load(32'hFFFF_FFFF);
    set_count(11'd1);
    repeat (3) draw(16'hFFFF);
    set_count(11'd2);
    repeat (2) draw(16'hFFFF);

    // wheel index left beyond a smaller count
    set_count(11'd8);
    start(16'h0000);
    repeat (8) load($urandom);
    start(16'hFFFF);
    set_count(11'd4);
    draw(rand_frac());

    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 15) set_count(pick_count());
      if (roll < 75) begin
        style = $urandom_range(0, 3);
        start(rand_frac());
        repeat (count_now) load(pick_weight(style));
        holding = 1'b0;
        if (!hold_done && items_sent - base > RANDOM_ITEMS / 3) begin
          hold_req = 1'b1;
          hold_done = 1'b1;
          holding = 1'b1;
        end
        start(rand_frac());
        ndraw = (count_now > 24) ? $urandom_range(1, 24) : $urandom_range(1, count_now + 3);
        if (holding && ndraw < 8) ndraw = 8;
        repeat (ndraw) draw(rand_frac());
      end else begin
        repeat ($urandom_range(4, 16)) begin
          cmd = CMD_W'($urandom_range(0, 3));
          if (cmd == CMD_DRAW && !set_loaded()) cmd = CMD_LOAD;
          send(cmd, pick_weight($urandom_range(0, 3)), rand_frac());
        end
      end
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/rws_pkg.sv
sv/rws_weight_mem.sv
sv/rws_mul.sv
sv/resampling_wheel_selector.sv
sv/rws_checker.sv
tb/rws_checker.sv
tb/tb_resampling_wheel_selector.sv
